// ----- hdl/lcdn_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types and constants for the 4-bit character LCD bus driver.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdn_pkg;

  localparam int OPCODE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 8;
  localparam int NIB_W    = 4;
  localparam int TICK_W   = 16;
  localparam int HOLD_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W   = 4;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_INIT   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CMD    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_DATA   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_CURSOR = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_PULSE = 2'd2;

  localparam logic [TICK_W-1:0] PULSE_RST      = 16'd10;
  localparam logic [TICK_W-1:0] SETTLE_RST     = 16'd50000;
  localparam logic [TICK_W-1:0] DATA_PULSE_RST = 16'd50000;

  // controller bytes and wake-up nibbles
  localparam logic [BYTE_W-1:0] WAKE_8BIT   = 8'h30;
  localparam logic [BYTE_W-1:0] WAKE_4BIT   = 8'h28;
  localparam logic [BYTE_W-1:0] CMD_DISPLAY = 8'h0F;
  localparam logic [BYTE_W-1:0] CMD_CLEAR   = 8'h01;
  localparam logic [BYTE_W-1:0] CURSOR_L0   = 8'h80;
  localparam logic [BYTE_W-1:0] CURSOR_L1   = 8'hC0;

  // step numbers within a sequence
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP    = 4'd3;
  localparam logic [STEP_W-1:0] INIT_WAKE4_STEP   = 4'd5;
  localparam logic [STEP_W-1:0] INIT_DISPLAY_STEP = 4'd7;
  localparam logic [STEP_W-1:0] INIT_CLEAR_STEP   = 4'd11;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP    = 4'd14;

  typedef struct packed {
    logic              load;
    logic              prep;
    logic [STEP_W-1:0] step;
    logic              last;
  } lcdn_cmd_t;

  typedef struct packed {
    logic op_ok;
    logic is_init;
  } lcdn_status_t;

endpackage

`default_nettype wire

// ----- hdl/lcdn_if.sv -----
// ----------------------------------------------------------------------------
// lcdn channel interfaces
// Valid/ready channels for LCD operations in and timed pin states out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdn_op_if;
  logic                           valid;
  logic                           ready;
  logic [lcdn_pkg::OPCODE_W-1:0]  opcode;
  logic [lcdn_pkg::BYTE_W-1:0]    value;
  logic                           row;
  logic [lcdn_pkg::COL_W-1:0]     column;

  modport source (output valid, opcode, value, row, column, input ready);
  modport sink   (input valid, opcode, value, row, column, output ready);
endinterface

interface lcdn_pin_if;
  logic                         valid;
  logic                         ready;
  logic [lcdn_pkg::NIB_W-1:0]   nibble;
  logic                         reg_select;
  logic                         enable;
  logic [lcdn_pkg::HOLD_W-1:0]  hold_ticks;
  logic                         last;

  modport source (output valid, nibble, reg_select, enable, hold_ticks, last,
                  input ready);
  modport sink   (input valid, nibble, reg_select, enable, hold_ticks, last,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/lcdn_datapath.sv -----
// ----------------------------------------------------------------------------
// lcdn_datapath
// Operation registers, timing registers and pin state generation.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdn_datapath #(
  parameter int COLUMNS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [lcdn_pkg::OPCODE_W-1:0]   in_opcode,
  input  wire logic [lcdn_pkg::BYTE_W-1:0]     in_value,
  input  wire logic                            in_row,
  input  wire logic [lcdn_pkg::COL_W-1:0]      in_column,
  input  wire logic                            cfg_we,
  input  wire logic [lcdn_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [lcdn_pkg::TICK_W-1:0]     cfg_wdata,
  input  wire lcdn_pkg::lcdn_cmd_t             cmd,
  output lcdn_pkg::lcdn_status_t               status,
  output logic [lcdn_pkg::NIB_W-1:0]           out_nibble,
  output logic                                 out_reg_select,
  output logic                                 out_enable,
  output logic [lcdn_pkg::HOLD_W-1:0]          out_hold_ticks,
  output logic                                 out_last
);
  import lcdn_pkg::*;

  // column mod COLUMNS by reciprocal multiply; exact for 8-bit columns
  localparam int RECIP_SH = 16;
  localparam int RECIP    = ((1 << RECIP_SH) + COLUMNS - 1) / COLUMNS;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = COL_W + RECIP_W;
  localparam int REM_W    = $clog2(COLUMNS);

  logic [TICK_W-1:0]   pulse_r, settle_r, data_pulse_r;
  logic [OPCODE_W-1:0] opcode_r;
  logic [BYTE_W-1:0]   value_r;
  logic                row_r;
  logic [COL_W-1:0]    column_r;
  logic [BYTE_W-1:0]   byte_r;
  logic [BYTE_W-1:0]   byte_nxt;

  logic [PROD_W-1:0]   prod;
  logic [COL_W-1:0]    quot;
  logic [COL_W:0]      quot_cols;
  logic [REM_W-1:0]    col_rem;
  logic [BYTE_W-1:0]   cursor_byte;

  logic [1:0]          t;
  logic [BYTE_W-1:0]   b;
  logic                clr_tail;
  logic [TICK_W-1:0]   high_hold;

  // timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r      <= PULSE_RST;
      settle_r     <= SETTLE_RST;
      data_pulse_r <= DATA_PULSE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PULSE:      pulse_r      <= cfg_wdata;
        CFG_SETTLE:     settle_r     <= cfg_wdata;
        CFG_DATA_PULSE: data_pulse_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // operation capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode_r <= in_opcode;
      value_r  <= in_value;
      row_r    <= in_row;
      column_r <= in_column;
    end
    if (cmd.prep) begin
      byte_r <= byte_nxt;
    end
  end

  always_comb begin
    prod        = PROD_W'(column_r) * PROD_W'(RECIP);
    quot        = COL_W'(prod >> RECIP_SH);
    quot_cols   = (COL_W+1)'(quot * (COL_W+1)'(COLUMNS));
    col_rem     = REM_W'((COL_W+1)'(column_r) - quot_cols);
    cursor_byte = (row_r ? CURSOR_L1 : CURSOR_L0) + BYTE_W'(col_rem);
    case (opcode_r)
      OP_CMD,
      OP_DATA:   byte_nxt = value_r;
      OP_CURSOR: byte_nxt = cursor_byte;
      OP_CLEAR:  byte_nxt = CMD_CLEAR;
      default:   byte_nxt = '0;
    endcase
  end

  assign status.op_ok   = (in_opcode <= OP_CLEAR);
  assign status.is_init = (opcode_r == OP_INIT);

  // pin state for the current step
  always_comb begin
    high_hold      = (opcode_r == OP_DATA) ? data_pulse_r : pulse_r;
    out_reg_select = (opcode_r == OP_DATA);
    out_last       = cmd.last;
    t              = cmd.step[1:0];
    b              = byte_r;
    out_nibble     = '0;
    out_enable     = 1'b0;
    out_hold_ticks = HOLD_W'(settle_r);
    if (status.is_init && cmd.step < INIT_DISPLAY_STEP) begin
      // power-up wait, then the three wake nibbles
      if (cmd.step != '0) begin
        out_nibble = (cmd.step >= INIT_WAKE4_STEP) ? WAKE_4BIT[7:4] : WAKE_8BIT[7:4];
        out_enable = cmd.step[0];
        out_hold_ticks = out_enable ? HOLD_W'(pulse_r) : HOLD_W'(settle_r);
      end
      clr_tail = 1'b0;
    end else begin
      if (status.is_init) begin
        if (cmd.step < INIT_CLEAR_STEP) begin
          t = 2'(cmd.step - INIT_DISPLAY_STEP);
          b = CMD_DISPLAY;
        end else begin
          t = 2'(cmd.step - INIT_CLEAR_STEP);
          b = CMD_CLEAR;
        end
      end
      clr_tail = (t == 2'd3) &&
                 ((status.is_init && cmd.step >= INIT_CLEAR_STEP) ||
                  (opcode_r == OP_CLEAR));
      out_nibble = t[1] ? b[3:0] : b[7:4];
      out_enable = ~t[0];
      if (clr_tail) begin
        out_hold_ticks = HOLD_W'(settle_r) + HOLD_W'(pulse_r);
      end else if (out_enable) begin
        out_hold_ticks = HOLD_W'(high_hold);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lcdn_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcdn_ctrl
// Sequencer: takes one operation, then steps through its pin states.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdn_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire lcdn_pkg::lcdn_status_t status,
  output lcdn_pkg::lcdn_cmd_t         cmd
);
  import lcdn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PREP = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [STEP_W-1:0] last_step;

  assign last_step = status.is_init ? INIT_LAST_STEP : BYTE_LAST_STEP;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.prep  = 1'b0;
    cmd.step  = step_r;
    cmd.last  = (step_r == last_step);
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // unused opcodes are taken and dropped
        if (in_valid && status.op_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (cmd.last) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a pin state is offered");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(step_r)))
    else $error("step moved during a stalled transfer");

  a_prep_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREP) |=> (out_valid && step_r == '0))
    else $error("sequence did not start at step zero");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && cmd.last) |=> in_ready)
    else $error("sequencer did not return to idle after final state");

endmodule

`default_nettype wire

// ----- hdl/char_lcd_nibble_interface_top.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_top
// Expands LCD operations into timed 4-bit bus pin states.
// ----------------------------------------------------------------------------
// Usage:
//   in_op  : one operation per transfer (init, command, data, cursor, clear).
//   out_pin: one pin state per transfer (D7..D4, RS, E, hold ticks, last).
//   cfg_*  : write-only timing registers (pulse, settle, data pulse ticks),
//            written by the user only while the block is idle, not enforced.
// Timing:
//   An operation is taken in the idle state, builds its byte in the prep
//   state, then offers one pin state per cycle while out_pin.ready is high.
//   A byte operation has 4 pin states, init has 15; the sequencer's step
//   counter runs through them. Unused opcodes are taken in the idle state
//   and produce nothing.
// Reset (synchronous, rst_n low): sequencer returns to idle, timing
//   registers go to 10 / 50000 / 50000.
// Stall: while out_pin.ready is low the offered pin state holds and no new
//   operation is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_interface_top #(
  parameter int COLUMNS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lcdn_op_if.sink                              in_op,
  lcdn_pin_if.source                           out_pin,
  input  wire logic                            cfg_we,
  input  wire logic [lcdn_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [lcdn_pkg::TICK_W-1:0]     cfg_wdata
);
  import lcdn_pkg::*;

  lcdn_cmd_t    cmd;
  lcdn_status_t status;

  lcdn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_op.valid),
    .in_ready  (in_op.ready),
    .out_valid (out_pin.valid),
    .out_ready (out_pin.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcdn_datapath #(
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_op.opcode),
    .in_value       (in_op.value),
    .in_row         (in_op.row),
    .in_column      (in_op.column),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .status         (status),
    .out_nibble     (out_pin.nibble),
    .out_reg_select (out_pin.reg_select),
    .out_enable     (out_pin.enable),
    .out_hold_ticks (out_pin.hold_ticks),
    .out_last       (out_pin.last)
  );

endmodule

`default_nettype wire
